>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the project.
// Each macro expands to one labelled concurrent assertion that is
// switched off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hdl/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// Prefix code bit packer package
// Transaction types, operation codes and fixed field widths shared by the
// packer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbp_pkg;

    localparam int OP_W            = 2;
    localparam int SYM_W           = 8;
    localparam int WORD_FIELD_BITS = 24;
    localparam int LEN_W           = 5;
    localparam int BYTE_BITS       = 8;
    localparam int RES_W           = 7;
    localparam int RES_CNT_W       = 3;
    localparam int MAX_RESULTS     = 3;
    localparam int GRP_IDX_W       = 2;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic [SYM_W-1:0]           symbol;
        logic [WORD_FIELD_BITS-1:0] code_word;
        logic [LEN_W-1:0]           code_length;
    } item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 is_pad_count;
        logic                 last;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/prefix_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// Prefix code bit packer
// Packs table-driven prefix codes MSB first into a byte stream, with a
// flush that pads the final byte and reports the number of pad bits.
// ----------------------------------------------------------------------------
// Usage
//   Input transactions arrive on item/item_valid/item_stall. A load writes
//   one code table entry, an encode appends the code of its symbol to the
//   pending bits, and a flush closes the stream. Output transactions leave
//   on result/result_valid/result_stall, one byte per transaction; the last
//   byte caused by an input transaction carries last, and the pad count
//   byte of a flush also carries is_pad_count.
//   The code table sits in a synchronous memory. An accepted transaction
//   reads its entry at the accepting edge; the next cycle merges the entry
//   with the pending bits and, once the group register is free, loads a
//   result group of one to three bytes, from which the bytes are offered.
//   The block takes one input transaction per cycle as long as each gives
//   at most one byte and the receiver does not stall; a transaction that
//   gives more bytes holds the output while they leave one at a time.
//   Loads write the table at the accepting edge, so an encode accepted in
//   the very next cycle already sees the new entry.
//   Reset clears the pending bits and all handshake state; the table
//   keeps whatever it held and must be loaded before use.
//   When the receiver stalls, the current byte holds, and item_stall rises
//   once the merge stage has a group waiting behind the busy output.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_code_bit_packer_unit #(
    parameter int MAX_CODE_BITS = 24,
    parameter int SYMBOLS       = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pcbp_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output pcbp_pkg::result_t result
);
    import pcbp_pkg::*;

    // Codes are stored no wider than the input field can carry.
    localparam int CAP_BITS = (MAX_CODE_BITS < WORD_FIELD_BITS) ? MAX_CODE_BITS
                                                                 : WORD_FIELD_BITS;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP_BITS);
    localparam int IDX_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOLS);
    localparam int ENTRY_W = LEN_W + CAP_BITS;
    localparam int ACC_W   = RES_W + CAP_BITS;

    // Code table: length above the right-aligned code word.
    logic [ENTRY_W-1:0] code_mem [SYMBOLS];
    logic [ENTRY_W-1:0] code_rd_reg;

    // Input side decode.
    logic                       item_fire;
    logic                       sym_ok;
    logic [IDX_W-1:0]           item_idx;
    logic [LEN_W-1:0]           len_sat;
    logic [WORD_FIELD_BITS:0]   len_mask;
    logic [WORD_FIELD_BITS-1:0] word_masked;
    logic                       mem_wr;

    // Merge stage.
    logic s1_valid_reg, s1_valid_next;
    logic s1_flush_reg, s1_flush_next;
    logic s1_go;

    // Pending bits between transactions.
    logic [RES_W-1:0]     res_bits_reg, res_bits_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    // Merge arithmetic.
    logic [LEN_W-1:0]     ent_len;
    logic [CAP_BITS-1:0]  ent_word;
    logic [ACC_W-1:0]     acc;
    logic [LEN_W-1:0]     cnt;
    logic [RES_W-1:0]     keep_mask;
    logic [RES_CNT_W-1:0] pad_bits;
    logic [BYTE_BITS-1:0] pad_data;
    logic [BYTE_BITS-1:0] enc_byte [MAX_RESULTS];
    logic [BYTE_BITS-1:0] new_byte [MAX_RESULTS];
    logic [GRP_IDX_W-1:0] new_n;

    // Result group register.
    logic                 grp_valid_reg, grp_valid_next;
    logic [BYTE_BITS-1:0] grp_byte_reg [MAX_RESULTS];
    logic [BYTE_BITS-1:0] grp_byte_next [MAX_RESULTS];
    logic [GRP_IDX_W-1:0] grp_n_reg, grp_n_next;
    logic [GRP_IDX_W-1:0] grp_idx_reg, grp_idx_next;
    logic                 grp_pad_reg, grp_pad_next;
    logic                 grp_last;
    logic                 grp_done;
    logic                 grp_load;
    logic [BYTE_BITS-1:0] grp_cur_byte;

    // ------------------------------------------------------------------
    // Input acceptance and table access
    // ------------------------------------------------------------------
    assign item_fire = item_valid && !item_stall;
    assign sym_ok    = {1'b0, item.symbol} < SYM_LIMIT;
    assign item_idx  = item.symbol[IDX_W-1:0];

    // A loaded length is saturated and the word trimmed to it.
    assign len_sat     = (item.code_length > CAP_LEN) ? CAP_LEN : item.code_length;
    assign len_mask    = ((WORD_FIELD_BITS + 1)'(1) << len_sat) - (WORD_FIELD_BITS + 1)'(1);
    assign word_masked = item.code_word & len_mask[WORD_FIELD_BITS-1:0];
    assign mem_wr      = item_fire && (item.op == OP_LOAD) && sym_ok;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            code_mem[item_idx] <= {len_sat, word_masked[CAP_BITS-1:0]};
        end
        if (item_fire)
        begin
            code_rd_reg <= code_mem[item_idx];
        end
    end

    // Only encodes of a valid symbol and flushes reach the merge stage;
    // loads and unused codes end at the input.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_flush_next = s1_flush_reg;
        if (item_fire)
        begin
            s1_valid_next = ((item.op == OP_ENCODE) && sym_ok) || (item.op == OP_FLUSH);
            s1_flush_next = (item.op == OP_FLUSH);
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign item_stall = s1_valid_reg && !s1_go;

    // ------------------------------------------------------------------
    // Merge of the table entry with the pending bits
    // ------------------------------------------------------------------
    assign ent_len   = code_rd_reg[ENTRY_W-1 -: LEN_W];
    assign ent_word  = code_rd_reg[CAP_BITS-1:0];
    assign acc       = (ACC_W'(res_bits_reg) << ent_len) | ACC_W'(ent_word);
    assign cnt       = LEN_W'(res_cnt_reg) + ent_len;
    assign keep_mask = RES_W'((8'(1) << cnt[RES_CNT_W-1:0]) - 8'(1));

    // Pad count wraps to zero when nothing is pending.
    assign pad_bits = RES_CNT_W'(0) - res_cnt_reg;
    assign pad_data = BYTE_BITS'(res_bits_reg) << pad_bits;

    always_comb
    begin
        logic [ACC_W-1:0] shifted;
        shifted = '0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            shifted     = acc >> (cnt - LEN_W'(BYTE_BITS * (k + 1)));
            enc_byte[k] = shifted[BYTE_BITS-1:0];
        end
    end

    always_comb
    begin
        new_byte = enc_byte;
        new_n    = cnt[LEN_W-1 -: GRP_IDX_W];
        if (s1_flush_reg)
        begin
            if (res_cnt_reg != '0)
            begin
                new_n       = GRP_IDX_W'(2);
                new_byte[0] = pad_data;
                new_byte[1] = BYTE_BITS'(pad_bits);
            end
            else
            begin
                new_n       = GRP_IDX_W'(1);
                new_byte[0] = BYTE_BITS'(pad_bits);
            end
        end
    end

    // The merge stage moves on when it has nothing to emit or the group
    // register is free, or frees up at this edge.
    assign s1_go    = (new_n == '0) || !grp_valid_reg || grp_done;
    assign grp_load = s1_valid_reg && (new_n != '0) && (!grp_valid_reg || grp_done);

    always_comb
    begin
        res_bits_next = res_bits_reg;
        res_cnt_next  = res_cnt_reg;
        if (s1_valid_reg && s1_go)
        begin
            if (s1_flush_reg)
            begin
                res_bits_next = '0;
                res_cnt_next  = '0;
            end
            else
            begin
                res_bits_next = acc[RES_W-1:0] & keep_mask;
                res_cnt_next  = cnt[RES_CNT_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result group: one byte per output transaction
    // ------------------------------------------------------------------
    assign grp_last = (grp_idx_reg + GRP_IDX_W'(1)) == grp_n_reg;
    assign grp_done = grp_valid_reg && !result_stall && grp_last;

    always_comb
    begin
        case (grp_idx_reg)
            2'd0:    grp_cur_byte = grp_byte_reg[0];
            2'd1:    grp_cur_byte = grp_byte_reg[1];
            default: grp_cur_byte = grp_byte_reg[2];
        endcase
    end

    always_comb
    begin
        grp_valid_next = grp_valid_reg;
        grp_byte_next  = grp_byte_reg;
        grp_n_next     = grp_n_reg;
        grp_idx_next   = grp_idx_reg;
        grp_pad_next   = grp_pad_reg;
        if (grp_load)
        begin
            grp_valid_next = 1'b1;
            grp_byte_next  = new_byte;
            grp_n_next     = new_n;
            grp_idx_next   = '0;
            grp_pad_next   = s1_flush_reg;
        end
        else if (grp_done)
        begin
            grp_valid_next = 1'b0;
        end
        else if (grp_valid_reg && !result_stall)
        begin
            grp_idx_next = grp_idx_reg + GRP_IDX_W'(1);
        end
    end

    assign result_valid        = grp_valid_reg;
    assign result.out_byte     = grp_cur_byte;
    assign result.is_pad_count = grp_pad_reg && grp_last;
    assign result.last         = grp_last;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_flush_reg  <= 1'b0;
            res_bits_reg  <= '0;
            res_cnt_reg   <= '0;
            grp_valid_reg <= 1'b0;
            grp_n_reg     <= '0;
            grp_idx_reg   <= '0;
            grp_pad_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_flush_reg  <= s1_flush_next;
            res_bits_reg  <= res_bits_next;
            res_cnt_reg   <= res_cnt_next;
            grp_valid_reg <= grp_valid_next;
            grp_n_reg     <= grp_n_next;
            grp_idx_reg   <= grp_idx_next;
            grp_pad_reg   <= grp_pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_byte_reg <= grp_byte_next;
    end

endmodule

`default_nettype wire

>>> hdl/pcbp_checker.sv
// ----------------------------------------------------------------------------
// Prefix code bit packer checker
// Port-level checks on the output transactions of the packer, attached to
// every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcbp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input pcbp_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input pcbp_pkg::result_t result
);
    import pcbp_pkg::*;

    logic [BYTE_BITS-1:0] seen_byte;
    logic                 in_busy;

    assign seen_byte = result.out_byte;
    assign in_busy   = item_valid && item_stall && (item.op != OP_NONE);

    // A stalled output transaction holds.
    `ASSERT_NEXT_CYCLE(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    // The pad count byte always closes its input transaction.
    `ASSERT_SAME_CYCLE(a_pad_is_last, clk, rst_n, result_valid && result.is_pad_count, result.last)
    // Fewer than eight pad bits are ever needed.
    `ASSERT_SAME_CYCLE(a_pad_range, clk, rst_n, result_valid && result.is_pad_count, seen_byte[BYTE_BITS-1:RES_CNT_W] == '0)
    // Bytes of one group follow without a gap, and input waits only on busy output.
    `ASSERT_NEXT_CYCLE(a_group_gapless, clk, rst_n, result_valid && !result_stall && !result.last, result_valid)
    `ASSERT_SAME_CYCLE(a_stall_cause, clk, rst_n, in_busy, result_valid)

endmodule

bind prefix_code_bit_packer_unit pcbp_checker u_pcbp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

>>> dv/prefix_code_bit_packer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prefix code bit packer testbench
// Drives load, encode, flush and unused-op transactions into the packer,
// predicts every output byte with an independent bit-accurate packer model
// and checks each byte transaction in order. Both handshakes idle and stall
// at random, and one phase holds the output off long enough to back the
// block up into its input.
// ----------------------------------------------------------------------------

module prefix_code_bit_packer_unit_tb;

    import pcbp_pkg::*;

    localparam int MAX_CODE_BITS = 24;
    localparam int SYMBOLS       = 256;
    // Loaded lengths saturate to the narrower of the parameter and the field.
    localparam int LEN_CAP = (MAX_CODE_BITS < WORD_FIELD_BITS) ? MAX_CODE_BITS
                                                               : WORD_FIELD_BITS;
    localparam int MAX_SHOWN      = 10;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int LONG_HOLD      = 150;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    prefix_code_bit_packer_unit #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .SYMBOLS       (SYMBOLS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // ------------------------------------------------------------------------
    // Packer model state. The table mirrors the block's code store; the
    // loaded flags keep the stimulus away from entries that were never written.
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0]           code_len_tbl  [SYMBOLS];
    logic [WORD_FIELD_BITS-1:0] code_word_tbl [SYMBOLS];
    bit                         entry_loaded  [SYMBOLS];
    logic [SYM_W-1:0]           loaded_syms   [$];
    logic [RES_W-1:0]           pend_bits;
    int                         pend_count;

    // Bytes that the block still owes, oldest first.
    result_t expected_bytes [$];

    int n_items;
    int n_bytes_checked;
    int n_flushes;
    int n_mismatches;

    // Idling controls shared between the test tasks and the two handshakes.
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_req;
    int rx_stall_left;

    // ------------------------------------------------------------------------
    // Clock, and a fixed limit on the whole run in case the block hangs.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the packer: works out the bytes that one accepted transaction
    // causes and queues them, with last on the final one.
    // ------------------------------------------------------------------------
    task automatic pack_item(input item_t it);
        logic [LEN_W-1:0] len;
        logic [63:0]      acc;
        int               cnt;
        int               n;
        result_t          grp [MAX_RESULTS];
        begin
            n = 0;
            case (it.op)
                OP_LOAD:
                begin
                    if (it.symbol < SYMBOLS)
                    begin
                        len = (it.code_length > LEN_CAP) ? LEN_W'(LEN_CAP) : it.code_length;
                        code_len_tbl[it.symbol]  = len;
                        code_word_tbl[it.symbol] = it.code_word
                                                   & WORD_FIELD_BITS'((64'd1 << len) - 1);
                        if (!entry_loaded[it.symbol])
                            loaded_syms.push_back(it.symbol);
                        entry_loaded[it.symbol] = 1'b1;
                    end
                end
                OP_ENCODE:
                begin
                    if (it.symbol < SYMBOLS)
                    begin
                        len = code_len_tbl[it.symbol];
                        acc = (64'(pend_bits) << len) | 64'(code_word_tbl[it.symbol]);
                        cnt = pend_count + int'(len);
                        // Emit whole bytes from the top of the accumulated bits.
                        while (cnt >= BYTE_BITS && n < MAX_RESULTS)
                        begin
                            cnt -= BYTE_BITS;
                            grp[n].out_byte     = BYTE_BITS'(acc >> cnt);
                            grp[n].is_pad_count = 1'b0;
                            grp[n].last         = 1'b0;
                            n++;
                        end
                        pend_count = cnt;
                        pend_bits  = RES_W'(acc & ((64'd1 << cnt) - 1));
                    end
                end
                OP_FLUSH:
                begin
                    // A partial byte is padded with zeros whenever any bits
                    // are pending, even when those bits are all zero.
                    if (pend_count != 0)
                    begin
                        grp[n].out_byte     = BYTE_BITS'(64'(pend_bits)
                                                         << (BYTE_BITS - pend_count));
                        grp[n].is_pad_count = 1'b0;
                        grp[n].last         = 1'b0;
                        n++;
                    end
                    grp[n].out_byte     = (pend_count != 0) ? BYTE_BITS'(BYTE_BITS - pend_count)
                                                            : '0;
                    grp[n].is_pad_count = 1'b1;
                    grp[n].last         = 1'b0;
                    n++;
                    pend_bits  = '0;
                    pend_count = 0;
                    n_flushes++;
                end
                default:
                begin
                    // The unused operation is ignored altogether.
                end
            endcase
            if (n > 0)
                grp[n-1].last = 1'b1;
            for (int k = 0; k < n; k++)
                expected_bytes.push_back(grp[k]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Idle draw used by both sides: none at all when idling is switched off,
    // otherwise a random gap, with zero strongly favoured.
    // ------------------------------------------------------------------------
    function automatic int draw_wait(input bit on);
        if (!on || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic item_t make_item(input logic [OP_W-1:0] op,
                                        input logic [SYM_W-1:0] sym,
                                        input logic [WORD_FIELD_BITS-1:0] word,
                                        input logic [LEN_W-1:0] len);
        item_t it;
        it.op          = op;
        it.symbol      = sym;
        it.code_word   = word;
        it.code_length = len;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Sends one input transaction. The valid is only lowered when a gap is
    // drawn, so back-to-back transactions never see valid fall and rise in
    // the same time step. The model is updated at the accepting edge, which
    // is always ahead of the first byte that the transaction can cause.
    // ------------------------------------------------------------------------
    task automatic send_item(input item_t it);
        int gap;
        begin
            gap = draw_wait(tx_idle_on);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            item       <= it;
            item_valid <= 1'b1;
            do
                @(posedge clk);
            while (item_stall);
            pack_item(it);
            n_items++;
        end
    endtask

    // Stops offering and waits until every owed byte has come back, or a
    // generous limit has passed. The loop waits on the clock before its first
    // check, so that the valid is never lowered and raised in one time step.
    task automatic wait_results_done();
        int waited;
        begin
            waited     = 0;
            item_valid <= 1'b0;
            do
            begin
                @(posedge clk);
                waited++;
            end
            while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: one stall decision per cycle. A fresh idle count is drawn
    // after every accepted byte, and a long hold requested by a test is
    // counted down here in cycles.
    // ------------------------------------------------------------------------
    initial
    begin
        result_stall  <= 1'b0;
        rx_stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                rx_stall_left = draw_wait(rx_idle_on);
            if (rx_hold_req > 0)
            begin
                rx_stall_left = rx_hold_req;
                rx_hold_req   = 0;
            end
            if (rx_stall_left > 0)
            begin
                result_stall <= 1'b1;
                rx_stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte checker: every accepted byte is compared field by field with the
    // oldest owed byte. A byte that nobody owes is a failure too.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input result_t want,
                                   input result_t got);
        n_mismatches++;
        if (n_mismatches <= MAX_SHOWN)
            $display("%0t ns: %s: expected byte %02h pad %0b last %0b, got byte %02h pad %0b last %0b",
                     $realtime, what, want.out_byte, want.is_pad_count, want.last,
                     got.out_byte, got.is_pad_count, got.last);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("byte with nothing owed", '0, result);
            end
            else
            begin
                want = expected_bytes.pop_front();
                n_bytes_checked++;
                if (result.out_byte !== want.out_byte
                    || result.is_pad_count !== want.is_pad_count
                    || result.last !== want.last)
                    report_mismatch("byte mismatch", want, result);
            end
        end
    end

    // Random code length: mostly short codes, some long ones, and a few empty
    // or over-long lengths that the block has to saturate.
    function automatic logic [LEN_W-1:0] draw_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 12)
            return LEN_W'($urandom_range(25, 31));
        if (r < 30)
            return LEN_W'($urandom_range(13, 24));
        return LEN_W'($urandom_range(1, 12));
    endfunction

    function automatic item_t random_load();
        return make_item(OP_LOAD, SYM_W'($urandom_range(0, 255)),
                         WORD_FIELD_BITS'($urandom), draw_length());
    endfunction

    // Encodes only pick symbols whose entry has been written.
    function automatic item_t random_encode();
        return make_item(OP_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                         WORD_FIELD_BITS'($urandom), LEN_W'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // Directed corner cases: the shortest and longest codes, a saturated
    // length, an empty code, a word wider than its length, a flush with
    // nothing pending, a flush of all-zero pending bits, the unused
    // operation, and an encode that brings seven pending bits up to three
    // full bytes.
    // ------------------------------------------------------------------------
    task automatic test_directed();
        begin
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
            send_item(make_item(OP_LOAD, 8'h00, 24'h000001, 5'd1));
            send_item(make_item(OP_LOAD, 8'hFF, 24'hFFFFFF, 5'd24));
            send_item(make_item(OP_LOAD, 8'h55, 24'hABCDEF, 5'd31));
            send_item(make_item(OP_LOAD, 8'hAA, 24'h123456, 5'd0));
            send_item(make_item(OP_LOAD, 8'h0F, 24'hFFFFFF, 5'd3));
            send_item(make_item(OP_LOAD, 8'h80, 24'h000000, 5'd2));
            send_item(make_item(OP_FLUSH, 8'h00, 24'h000000, 5'd0));
            send_item(make_item(OP_ENCODE, 8'h00, 24'h000000, 5'd0));
            send_item(make_item(OP_FLUSH, 8'hFF, 24'hFFFFFF, 5'd31));
            send_item(make_item(OP_ENCODE, 8'hFF, 24'h000000, 5'd0));
            send_item(make_item(OP_ENCODE, 8'h55, 24'h000000, 5'd0));
            send_item(make_item(OP_ENCODE, 8'hAA, 24'h000000, 5'd0));
            send_item(make_item(OP_NONE, 8'hFF, 24'hFFFFFF, 5'd31));
            send_item(make_item(OP_ENCODE, 8'h0F, 24'h000000, 5'd0));
            repeat (4)
                send_item(make_item(OP_ENCODE, 8'h00, 24'h000000, 5'd0));
            send_item(make_item(OP_ENCODE, 8'hFF, 24'h000000, 5'd0));
            send_item(make_item(OP_FLUSH, 8'h00, 24'h000000, 5'd0));
            send_item(make_item(OP_ENCODE, 8'h80, 24'h000000, 5'd0));
            send_item(make_item(OP_FLUSH, 8'h00, 24'h000000, 5'd0));
            wait_results_done();
        end
    endtask

    // ------------------------------------------------------------------------
    // Random stream: a freshly loaded table, then mostly encodes with some
    // reloads, flushes and unused operations mixed in. The idling changes
    // between phases so that there are stretches with no gaps on either side.
    // ------------------------------------------------------------------------
    task automatic test_random_stream();
        int r;
        begin
            repeat (40)
                send_item(random_load());
            for (int i = 0; i < 200; i++)
            begin
                tx_idle_on = (i < 90) || (i >= 140);
                rx_idle_on = (i < 90) || (i >= 170);
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_item(random_encode());
                else if (r < 80)
                    send_item(random_load());
                else if (r < 92)
                    send_item(make_item(OP_FLUSH, SYM_W'($urandom),
                                        WORD_FIELD_BITS'($urandom), LEN_W'($urandom)));
                else
                    send_item(make_item(OP_NONE, SYM_W'($urandom),
                                        WORD_FIELD_BITS'($urandom), LEN_W'($urandom)));
            end
            send_item(make_item(OP_FLUSH, 8'h00, 24'h000000, 5'd0));
            wait_results_done();
        end
    endtask

    // ------------------------------------------------------------------------
    // Backpressure: the receiver holds off for a long stretch while the
    // sender keeps offering long codes, so the block fills and stalls its
    // input. After that the sender pauses until every byte is back before
    // finishing with a short burst and a flush.
    // ------------------------------------------------------------------------
    task automatic test_backpressure();
        begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
            send_item(make_item(OP_LOAD, 8'hC3, 24'hA5F00F, 5'd24));
            send_item(make_item(OP_LOAD, 8'h3C, 24'h00005B, 5'd7));
            rx_hold_req = LONG_HOLD;
            for (int i = 0; i < 24; i++)
                send_item(make_item(OP_ENCODE, (i % 3 == 0) ? 8'h3C : 8'hC3,
                                    24'h000000, 5'd0));
            wait_results_done();
            rx_idle_on = 1'b1;
            for (int i = 0; i < 8; i++)
                send_item(random_encode());
            send_item(make_item(OP_FLUSH, 8'h00, 24'h000000, 5'd0));
            wait_results_done();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset once, run the tests, let the block settle, report.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        rx_hold_req  = 0;
        pend_bits    = '0;
        pend_count   = 0;
        n_items      = 0;
        n_bytes_checked = 0;
        n_flushes    = 0;
        n_mismatches = 0;
        for (int s = 0; s < SYMBOLS; s++)
        begin
            code_len_tbl[s]  = '0;
            code_word_tbl[s] = '0;
            entry_loaded[s]  = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_stream();
        test_backpressure();

        // Any byte that turns up during the settle time is flagged by the
        // checker as one that nobody owes.
        item_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            $display("%0d owed bytes never arrived", expected_bytes.size());
            n_mismatches++;
        end

        $display("Sent %0d transactions (loads, encodes, %0d flushes, unused ops) under random idling and a long output hold.",
                 n_items, n_flushes);
        $display("Checked %0d output bytes, %0d mismatches.", n_bytes_checked, n_mismatches);
        if (n_mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
